// ===== rtl/core/dcc_pkg.sv =====
package dcc_pkg;

	localparam int ValW = 14;

	localparam logic [ValW-1:0] TimeStepRst      = ValW'(5);
	localparam logic [ValW-1:0] VolumeStepRst    = ValW'(50);
	localparam logic [ValW-1:0] VolumePerTickRst = ValW'(11);
	localparam logic [ValW-1:0] ValueLimitRst    = ValW'(9999);
	localparam logic [ValW-1:0] TimeLevelRst     = ValW'(60);
	localparam logic [ValW-1:0] VolumeLevelRst   = ValW'(1700);
	localparam logic [ValW-1:0] TimeTickDec      = ValW'(1);

	typedef logic [ValW-1:0] val_t;

	// event codes
	typedef enum logic [2:0] {
		EV_TICK   = 3'd0,
		EV_BUTTON = 3'd1,
		EV_TOGGLE = 3'd2,
		EV_UP     = 3'd3,
		EV_DOWN   = 3'd4,
		EV_SET    = 3'd5
	} mode_t;

	// register indexes
	typedef enum logic [1:0] {
		REG_TIME_STEP   = 2'd0,
		REG_VOLUME_STEP = 2'd1,
		REG_VOL_PER_TICK = 2'd2,
		REG_VALUE_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		val_t time_step;
		val_t volume_step;
		val_t volume_per_tick;
		val_t value_limit;
	} cfg_t;

	typedef struct packed {
		logic auto_closed;
		val_t shown_value;
		logic shows_time;
		logic valve_on;
	} res_t;

endpackage

// ===== rtl/core/dcc_cfg.sv =====
module dcc_cfg import dcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  val_t       wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// write one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step       <= TimeStepRst;
			cfg_q.volume_step     <= VolumeStepRst;
			cfg_q.volume_per_tick <= VolumePerTickRst;
			cfg_q.value_limit     <= ValueLimitRst;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TIME_STEP:    cfg_q.time_step       <= wr_data;
				REG_VOLUME_STEP:  cfg_q.volume_step     <= wr_data;
				REG_VOL_PER_TICK: cfg_q.volume_per_tick <= wr_data;
				REG_VALUE_LIMIT:  cfg_q.value_limit     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/dcc_core.sv =====
module dcc_core import dcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [2:0] mode,
	input  val_t       new_value,
	input  cfg_t       cfg,
	output res_t       res
);

	val_t time_q, time_saved_q, vol_q, vol_saved_q;
	logic sel_q, valve_q;

	val_t           live, saved, step, dec;
	val_t           n_live, n_saved, n_time, n_vol, n_time_sv, n_vol_sv;
	logic           n_sel, n_valve, auto_cl;
	logic [ValW:0]  sum;
	val_t           sub_live, sub_step, ticked;

	// select the live setpoint and its amounts
	always_comb begin
		live     = sel_q ? time_q : vol_q;
		saved    = sel_q ? time_saved_q : vol_saved_q;
		step     = sel_q ? cfg.time_step : cfg.volume_step;
		dec      = sel_q ? TimeTickDec : cfg.volume_per_tick;
		sum      = {1'b0, live} + {1'b0, step};
		sub_step = (live > step) ? live - step : '0;
		ticked   = (live > dec) ? live - dec : '0;
		sub_live = live;
	end

	// apply the event
	always_comb begin
		n_live  = sub_live;
		n_saved = saved;
		n_sel   = sel_q;
		n_valve = valve_q;
		auto_cl = 1'b0;
		unique case (mode_t'(mode))
			EV_TICK: begin
				if (valve_q) begin
					if (ticked == '0) begin
						n_live  = saved;
						n_valve = 1'b0;
						auto_cl = 1'b1;
					end else begin
						n_live = ticked;
					end
				end
			end
			EV_BUTTON: begin
				if (valve_q) begin
					n_live  = saved;
					n_valve = 1'b0;
				end else begin
					n_valve = 1'b1;
					n_saved = live;
				end
			end
			EV_TOGGLE: begin
				if (!valve_q) n_sel = !sel_q;
			end
			EV_UP: begin
				n_live = (sum > {1'b0, cfg.value_limit}) ? cfg.value_limit : sum[ValW-1:0];
			end
			EV_DOWN: begin
				n_live = sub_step;
			end
			EV_SET: begin
				n_live = (new_value > cfg.value_limit) ? cfg.value_limit : new_value;
			end
			default: ;
		endcase
		n_time    = sel_q ? n_live : time_q;
		n_vol     = sel_q ? vol_q : n_live;
		n_time_sv = sel_q ? n_saved : time_saved_q;
		n_vol_sv  = sel_q ? vol_saved_q : n_saved;
	end

	// hold state between events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q       <= TimeLevelRst;
			time_saved_q <= TimeLevelRst;
			vol_q        <= VolumeLevelRst;
			vol_saved_q  <= VolumeLevelRst;
			sel_q        <= 1'b0;
			valve_q      <= 1'b0;
		end else if (en) begin
			time_q       <= n_time;
			time_saved_q <= n_time_sv;
			vol_q        <= n_vol;
			vol_saved_q  <= n_vol_sv;
			sel_q        <= n_sel;
			valve_q      <= n_valve;
		end
	end

	assign res.valve_on    = n_valve;
	assign res.shows_time  = n_sel;
	assign res.shown_value = n_sel ? n_time : n_vol;
	assign res.auto_closed = auto_cl;

endmodule

// ===== rtl/core/dispense_countdown_controller.sv =====
// channel   dir  handshake             payload
// s_axis    in   s_tvalid / s_tready   tdata: new_value; tuser: mode
// m_axis    out  m_tvalid / m_tready   tdata: valve_on, shows_time, shown_value, auto_closed
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One event per cycle while the output is not stalled; each event leaves the input register
// and its result enters the output register once the output register frees up.
// The state update is one combinational pass from the input register.
// Reset clears state and setpoints to their defaults and empties both registers.
// A stalled output holds its result; the input register still fills behind it.
module dispense_countdown_controller import dcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [13:0] new_value, rest zero
	input  logic [2:0]  s_tuser,   // [2:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] valve_on, [1] shows_time, [15:2] shown_value,
	                               // [16] auto_closed, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	cfg_t       cfg;
	res_t       res, res_q;
	logic       vld_s1, out_vld_q;
	logic [2:0] mode_s1;
	val_t       nv_s1;
	logic       adv;

	assign cfg_ready = 1'b1;

	dcc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// move the input-stage event forward when the output register frees up
	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	dcc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.mode      (mode_s1),
		.new_value (nv_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			nv_s1   <= s_tdata[ValW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, res_q};

endmodule
